>>> src/bfiq_pkg.sv
// Package for the Bloom filter insert/query block.
// Holds opcodes, result kinds, hash constants and the controller/datapath structs.
// No dependencies.
`default_nettype none

package bfiq_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   // Hash constants.
   localparam logic [31:0] HASH_MUL   = 32'hc6a4a793;
   localparam logic [31:0] HASH_SEED  = 32'hbc9f1d34;
   localparam int          ROT_DELTA  = 17;
   localparam int          ROT_LEFT   = 15;
   localparam int          SHIFT_FULL = 16;
   localparam int          SHIFT_TAIL = 24;

   // The remainder unit retires two dividend bits per cycle.
   localparam int          DIV_STEPS  = 16;
   localparam int          DIV_CNT_W  = 4;

   // Configuration register map.
   localparam int          CSR_ADDR_W       = 3;
   localparam logic        REG_FILTER_BYTES = 1'b0;
   localparam logic        REG_PROBE_COUNT  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic acc_clear;
      logic clr_step;
      logic seed_mul;
      logic seed_mix;
      logic word_mul;
      logic word_mix;
      logic probe_init;
      logic div_step;
      logic ram_rd;
      logic ram_wr;
      logic probe_advance;
      logic maybe_set;
      logic maybe_clr;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       last;
      logic       nb_zero;
      logic       probe_skip;
      logic       div_done;
      logic       bit_set;
      logic       probe_last;
      logic       clr_done;
   } status_type;

endpackage

`default_nettype wire

>>> src/bfiq_req_if.sv
// Request channel interface: one key word or a clear request.
// Depends on nothing.
`default_nettype none

interface bfiq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] key_word;
   logic [2:0]  word_bytes;
   logic [15:0] key_length;
   logic        last;

   modport source (output valid, op, key_word, word_bytes, key_length, last, input ready);
   modport sink   (input valid, op, key_word, word_bytes, key_length, last, output ready);
endinterface

`default_nettype wire

>>> src/bfiq_rsp_if.sv
// Response channel interface: clear done, insert done or query answer.
// Depends on nothing.
`default_nettype none

interface bfiq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        maybe_present;
   logic [31:0] key_hash;

   modport source (output valid, kind, maybe_present, key_hash, input ready);
   modport sink   (input valid, kind, maybe_present, key_hash, output ready);
endinterface

`default_nettype wire

>>> src/bloom_filter_insert_query.sv
// Top level of the Bloom filter insert/query block: configuration registers
// and the controller/datapath pair. Uses bfiq_pkg, the channel interfaces,
// bfiq_ctrl and bfiq_datapath.
`default_nettype none

// Bloom filter with insert, query and clear requests. Keys arrive as
// little-endian 32-bit words, the final one marked last; each word is
// folded into a multiplicative 32-bit hash. A request is taken only while the
// block is idle. The first word of a key also derives the length seed. The
// last word of a key then runs k probes, k being probe_count (none if it is
// zero or above MAX_PROBES, or the filter size is zero): each runs the
// two-bits-per-cycle remainder unit for hash mod filter bits, one store read
// and one check or read-modify-write. A query stops at its first clear bit.
// A clear request sweeps the store one byte per cycle, all MAX_FILTER_BYTES
// bytes, and the same clearing pass runs once after reset before the first
// request is taken. The result waits in an output register, so the next
// request is taken while an earlier result is still pending.
module bloom_filter_insert_query #(
   parameter int MAX_FILTER_BYTES = 4096,
   parameter int MAX_PROBES       = 30
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   bfiq_req_if.sink                                req_bus,
   bfiq_rsp_if.source                              rsp_bus,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [bfiq_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready
);

   logic [12:0] filter_bytes_ff;
   logic [7:0]  probe_count_ff;
   logic        csr_wr;

   bfiq_pkg::cmd_type    cmd;
   bfiq_pkg::status_type status;

   // Configuration registers, written in the access phase.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bytes_ff <= '0;
         probe_count_ff  <= '0;
      end else if (csr_wr) begin
         case (paddr[2])
            bfiq_pkg::REG_FILTER_BYTES: filter_bytes_ff <= pwdata[12:0];
            bfiq_pkg::REG_PROBE_COUNT:  probe_count_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (paddr[2])
         bfiq_pkg::REG_FILTER_BYTES: prdata = 32'(filter_bytes_ff);
         bfiq_pkg::REG_PROBE_COUNT:  prdata = 32'(probe_count_ff);
         default:                    prdata = 32'd0;
      endcase
   end

   bfiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   bfiq_datapath #(
      .MAX_FILTER_BYTES (MAX_FILTER_BYTES),
      .MAX_PROBES       (MAX_PROBES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_bus.op),
      .req_key_word      (req_bus.key_word),
      .req_word_bytes    (req_bus.word_bytes),
      .req_key_length    (req_bus.key_length),
      .req_last          (req_bus.last),
      .filter_bytes      (filter_bytes_ff),
      .probe_count       (probe_count_ff),
      .rsp_kind          (rsp_bus.kind),
      .rsp_maybe_present (rsp_bus.maybe_present),
      .rsp_key_hash      (rsp_bus.key_hash)
   );

endmodule

`default_nettype wire

>>> src/bfiq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module bfiq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port; data holds while re is low.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/bfiq_datapath.sv
// Datapath: request capture, hash accumulator, remainder unit, probe state,
// filter store and the response payload register. Uses bfiq_pkg and bfiq_ram.
`default_nettype none

module bfiq_datapath #(
   parameter int MAX_FILTER_BYTES = 4096,
   parameter int MAX_PROBES       = 30
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bfiq_pkg::cmd_type     cmd,
   output bfiq_pkg::status_type       status,
   input  wire logic [1:0]            req_op,
   input  wire logic [31:0]           req_key_word,
   input  wire logic [2:0]            req_word_bytes,
   input  wire logic [15:0]           req_key_length,
   input  wire logic                  req_last,
   input  wire logic [12:0]           filter_bytes,
   input  wire logic [7:0]            probe_count,
   output logic      [1:0]            rsp_kind,
   output logic                       rsp_maybe_present,
   output logic      [31:0]           rsp_key_hash
);

   localparam int AW    = $clog2(MAX_FILTER_BYTES);
   localparam int BIT_W = $clog2(MAX_FILTER_BYTES * 8 + 1);
   localparam int RW    = BIT_W + 1;
   localparam int PW    = $clog2(MAX_PROBES + 1);

   localparam int DIV_CNT_W = bfiq_pkg::DIV_CNT_W;

   // Captured request fields.
   logic [1:0]  op_ff;
   logic [31:0] word_ff;
   logic [2:0]  nb_ff;
   logic [15:0] len_ff;
   logic        last_ff;

   // Hash and probe state.
   logic [31:0]          acc_ff, acc_in;
   logic [31:0]          prod_ff, prod_in;
   logic [31:0]          h_ff, h_in;
   logic [31:0]          delta_ff, delta_in;
   logic [31:0]          hdiv_ff, hdiv_in;
   logic [BIT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]        pidx_ff, pidx_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 maybe_ff, maybe_in;

   // Low 32 bits of the key length times the hash multiplier.
   function automatic logic [31:0] req_len_mul(input logic [15:0] len);
      return 32'(len) * bfiq_pkg::HASH_MUL;
   endfunction

   // Filter size in bits, with the byte count saturated at the store size.
   logic [31:0]      fb_wide, used_wide;
   logic [BIT_W-1:0] bits;
   assign fb_wide   = 32'(filter_bytes);
   assign used_wide = (fb_wide > 32'(MAX_FILTER_BYTES)) ? 32'(MAX_FILTER_BYTES) : fb_wide;
   assign bits      = BIT_W'(used_wide << 3);

   // Tail masking of the current word.
   logic [31:0] word_masked;
   logic        nb_full;
   always_comb begin
      case (nb_ff)
         3'd1:    word_masked = word_ff & 32'h0000_00ff;
         3'd2:    word_masked = word_ff & 32'h0000_ffff;
         3'd3:    word_masked = word_ff & 32'h00ff_ffff;
         default: word_masked = word_ff;
      endcase
   end
   assign nb_full = (nb_ff >= 3'd4);

   // Two restoring remainder steps per cycle.
   logic [RW-1:0] rem_work;
   logic [31:0]   hdiv_work;
   logic [BIT_W-1:0] rem_step;
   always_comb begin
      rem_work  = RW'(rem_ff);
      hdiv_work = hdiv_ff;
      for (int j = 0; j < 2; j++) begin
         rem_work  = {rem_work[RW-2:0], hdiv_work[31]};
         hdiv_work = {hdiv_work[30:0], 1'b0};
         if (rem_work >= RW'(bits)) begin
            rem_work = rem_work - RW'(bits);
         end
      end
      rem_step = rem_work[BIT_W-1:0];
   end

   // Store access.
   logic [AW-1:0] probe_addr;
   logic [7:0]    rdata, bit_mask;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   assign probe_addr = rem_ff[AW+2:3];
   assign bit_mask   = 8'(1) << rem_ff[2:0];
   assign ram_we     = cmd.clr_step | cmd.ram_wr;
   assign ram_waddr  = cmd.clr_step ? clr_addr_ff : probe_addr;
   assign ram_wdata  = cmd.clr_step ? 8'd0 : (rdata | bit_mask);

   bfiq_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FILTER_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.ram_rd),
      .raddr (probe_addr),
      .rdata (rdata)
   );

   // Next-state logic for hash, remainder and probe registers.
   always_comb begin
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      h_in        = h_ff;
      delta_in    = delta_ff;
      hdiv_in     = hdiv_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      pidx_in     = pidx_ff;
      clr_addr_in = clr_addr_ff;
      maybe_in    = maybe_ff;
      if (cmd.acc_clear) begin
         acc_in = 32'd0;
      end
      if (cmd.seed_mul) begin
         prod_in = 32'(req_len_mul(len_ff));
      end
      if (cmd.seed_mix) begin
         acc_in = bfiq_pkg::HASH_SEED ^ prod_ff;
      end
      if (cmd.word_mul) begin
         prod_in = (acc_ff + word_masked) * bfiq_pkg::HASH_MUL;
      end
      if (cmd.word_mix) begin
         acc_in = nb_full ? (prod_ff ^ (prod_ff >> bfiq_pkg::SHIFT_FULL))
                          : (prod_ff ^ (prod_ff >> bfiq_pkg::SHIFT_TAIL));
      end
      if (cmd.probe_init) begin
         h_in     = acc_ff;
         hdiv_in  = acc_ff;
         delta_in = (acc_ff >> bfiq_pkg::ROT_DELTA) | (acc_ff << bfiq_pkg::ROT_LEFT);
         rem_in   = '0;
         cnt_in   = '0;
         pidx_in  = '0;
      end
      if (cmd.div_step) begin
         rem_in  = rem_step;
         hdiv_in = hdiv_work;
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.probe_advance) begin
         h_in    = h_ff + delta_ff;
         hdiv_in = h_ff + delta_ff;
         rem_in  = '0;
         cnt_in  = '0;
         pidx_in = pidx_ff + PW'(1);
      end
      if (cmd.clr_step) begin
         clr_addr_in = (clr_addr_ff == AW'(MAX_FILTER_BYTES - 1)) ? '0
                                                                  : clr_addr_ff + AW'(1);
      end
      if (cmd.maybe_set) begin
         maybe_in = 1'b1;
      end
      if (cmd.maybe_clr) begin
         maybe_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         cnt_ff      <= '0;
         pidx_ff     <= '0;
         clr_addr_ff <= '0;
         maybe_ff    <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         pidx_ff     <= pidx_in;
         clr_addr_ff <= clr_addr_in;
         maybe_ff    <= maybe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      h_ff     <= h_in;
      delta_ff <= delta_in;
      hdiv_ff  <= hdiv_in;
      rem_ff   <= rem_in;
      if (cmd.capture) begin
         op_ff   <= req_op;
         word_ff <= req_key_word;
         nb_ff   <= req_word_bytes;
         len_ff  <= req_key_length;
         last_ff <= req_last;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (op_ff == bfiq_pkg::OP_CLEAR) begin
            rsp_kind          <= bfiq_pkg::KIND_CLEAR;
            rsp_maybe_present <= 1'b0;
            rsp_key_hash      <= 32'd0;
         end else if (op_ff == bfiq_pkg::OP_INSERT) begin
            rsp_kind          <= bfiq_pkg::KIND_INSERT;
            rsp_maybe_present <= 1'b0;
            rsp_key_hash      <= acc_ff;
         end else begin
            rsp_kind          <= bfiq_pkg::KIND_QUERY;
            rsp_maybe_present <= maybe_ff;
            rsp_key_hash      <= acc_ff;
         end
      end
   end

   // Status toward the controller.
   always_comb begin
      status.op         = op_ff;
      status.last       = last_ff;
      status.nb_zero    = (nb_ff == 3'd0);
      status.probe_skip = (used_wide == 32'd0) || (probe_count == 8'd0) ||
                          (probe_count > 8'(MAX_PROBES));
      status.div_done   = (cnt_ff == DIV_CNT_W'(bfiq_pkg::DIV_STEPS - 1));
      status.bit_set    = rdata[rem_ff[2:0]];
      status.probe_last = ((8'(pidx_ff) + 8'd1) == probe_count);
      status.clr_done   = (clr_addr_ff == AW'(MAX_FILTER_BYTES - 1));
   end

endmodule

`default_nettype wire

>>> src/bfiq_ctrl.sv
// Controller state machine: sequences hashing, probing, clearing and the response.
// Uses bfiq_pkg; talks to bfiq_datapath through command and status structs.
`default_nettype none

module bfiq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_op,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output bfiq_pkg::cmd_type         cmd,
   input  wire bfiq_pkg::status_type status
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SEED_MUL, S_SEED_MIX, S_WORD_MUL, S_WORD_MIX,
      S_POST, S_DIV, S_RD, S_CHK, S_CLR, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      in_key_ff, in_key_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Commands and next state.
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      in_key_in = in_key_ff;
      case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_op)
                  bfiq_pkg::OP_NONE: state_in = S_IDLE;
                  bfiq_pkg::OP_CLEAR: begin
                     cmd.acc_clear = 1'b1;
                     in_key_in     = 1'b0;
                     state_in      = S_CLR;
                  end
                  default: state_in = in_key_ff ? S_WORD_MUL : S_SEED_MUL;
               endcase
            end
         end
         S_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = S_SEED_MIX;
         end
         S_SEED_MIX: begin
            cmd.seed_mix = 1'b1;
            state_in     = S_WORD_MUL;
         end
         S_WORD_MUL: begin
            if (status.nb_zero) begin
               state_in = S_POST;
            end else begin
               cmd.word_mul = 1'b1;
               state_in     = S_WORD_MIX;
            end
         end
         S_WORD_MIX: begin
            cmd.word_mix = 1'b1;
            state_in     = S_POST;
         end
         S_POST: begin
            if (!status.last) begin
               in_key_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               in_key_in     = 1'b0;
               cmd.maybe_set = 1'b1;
               if (status.probe_skip) begin
                  state_in = S_RESP;
               end else begin
                  cmd.probe_init = 1'b1;
                  state_in       = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            // An insert marks the bit; a query stops at the first clear bit.
            if (status.op == bfiq_pkg::OP_INSERT) begin
               cmd.ram_wr = 1'b1;
            end
            if (status.op != bfiq_pkg::OP_INSERT && !status.bit_set) begin
               cmd.maybe_clr = 1'b1;
               state_in      = S_RESP;
            end else if (status.probe_last) begin
               state_in = S_RESP;
            end else begin
               cmd.probe_advance = 1'b1;
               state_in          = S_DIV;
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The output register empties when taken and fills on a load.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         in_key_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Probe writes only happen for inserts.
   a_wr_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_wr |-> status.op == bfiq_pkg::OP_INSERT)
      else $error("store write outside an insert");

   // Loading a response always leaves no key in progress.
   a_rsp_no_key: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> !in_key_ff)
      else $error("key still open after a response");

   // A new response appears only after the response state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");
`endif

endmodule

`default_nettype wire
